### src/ept_pkg.sv
// Shared types, constants and helpers for the elitist aging population table
package ept_pkg;

  localparam int FIT_W      = 32;
  localparam int ID_W       = 16;
  localparam int ENTRY_W    = FIT_W + ID_W;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELITE_COUNT = 1'b0,
    REG_TARGET_SIZE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [FIT_W-1:0] new_fitness;
    logic [ID_W-1:0]         new_id;
  } in_t;

  typedef struct packed {
    logic                    status;
    logic                    evicted;
    logic [ID_W-1:0]         evicted_id;
    logic signed [FIT_W-1:0] evicted_fitness;
    logic                    fallback_evict;
    logic [6:0]              population_size;
  } out_t;

  // Value the elite set sends to the age queue
  typedef struct packed {
    logic             valid;
    logic [FIT_W-1:0] value;
  } push_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_INS,
    S_ELITE,
    S_CHK,
    S_AGE_LAT,
    S_EV_RD,
    S_EV_LAT,
    S_SHDN,
    S_DONE
  } state_t;

  // Signed order on raw fitness bits
  function automatic logic fit_less(input logic [FIT_W-1:0] a, input logic [FIT_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

### src/elitist_aging_population_table_unit.sv
// Top level: sorted population table, age queue and insert/evict sequencer
// Run time from start to done is set by the walks over the table memory
// (one entry a cycle: search and shift up, then search and shift down).
// Throughput: one item at a time; busy stays high until the done cycle ends.
// The result stands on the ports for the single done cycle; the receiver cannot stall.
// Reset clears counts, queue pointers and config; memories are not cleared.
module elitist_aging_population_table_unit #(
  parameter int POP_MAX   = 64,
  parameter int ELITE_MAX = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  ept_pkg::in_t                      item,
  output logic                              done,
  output ept_pkg::out_t                     result,
  input  logic                              cfg_we,
  input  ept_pkg::reg_index_t               cfg_index,
  input  logic [ept_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW = $clog2(POP_MAX + 1);
  localparam int AW = $clog2(POP_MAX);
  localparam int CW = $clog2(POP_MAX + 1);

  ept_pkg::state_t state, state_next;

  logic [3:0] elite_count;
  logic [6:0] target_size;

  logic [PW-1:0] cnt, cnt_next, s, s_next, pos, pos_next, orig, orig_next;
  logic [ept_pkg::FIT_W-1:0] key, key_next, ev_fit, ev_fit_next;
  logic [ept_pkg::ID_W-1:0]  nid, nid_next, ev_id, ev_id_next;
  logic evp, evp_next, status, status_next, ev, ev_next, fb, fb_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] alen, alen_next;

  logic                         t_we;
  logic [PW-1:0]                t_waddr, t_raddr;
  logic [ept_pkg::ENTRY_W-1:0]  t_wdata, t_rdata;
  logic                         a_we;
  logic [AW-1:0]                a_waddr, a_raddr;
  logic [ept_pkg::FIT_W-1:0]    a_wdata, a_rdata;

  logic [ept_pkg::FIT_W-1:0] rd_fit;
  logic [ept_pkg::ID_W-1:0]  rd_id;
  logic                      less;
  logic [PW-1:0]             pos_sc;
  logic [AW-1:0]             h1;
  logic [CW-1:0]             l1;
  logic [CW:0]               asum;
  logic [31:0]               tgt;
  logic                      elite_step;
  ept_pkg::push_t            push;

  ept_ram #(.WIDTH(ept_pkg::ENTRY_W), .DEPTH(POP_MAX + 1)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  ept_ram #(.WIDTH(ept_pkg::FIT_W), .DEPTH(POP_MAX)) u_age (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  ept_elite #(.ELITE_MAX(ELITE_MAX)) u_elite (
    .clk(clk), .rst(rst), .elite_count(elite_count), .step(elite_step),
    .fit(key), .push(push)
  );

  assign rd_fit = t_rdata[ept_pkg::ENTRY_W-1:ept_pkg::ID_W];
  assign rd_id  = t_rdata[ept_pkg::ID_W-1:0];
  assign less   = ept_pkg::fit_less(rd_fit, key);
  assign pos_sc = less ? cnt : s;

  assign busy = (state != ept_pkg::S_IDLE);
  assign done = (state == ept_pkg::S_DONE);

  always_comb begin
    result.status          = status;
    result.evicted         = ev;
    result.evicted_id      = ev_id;
    result.evicted_fitness = ev_fit;
    result.fallback_evict  = fb;
    result.population_size = 7'(cnt);
  end

  // Age queue push address, dropping the oldest when full
  always_comb begin
    if (alen >= CW'(POP_MAX)) begin
      h1 = (head == AW'(POP_MAX - 1)) ? '0 : head + AW'(1);
      l1 = CW'(POP_MAX - 1);
    end else begin
      h1 = head;
      l1 = alen;
    end
    asum = (CW+1)'(h1) + (CW+1)'(l1);
    if (asum >= (CW+1)'(POP_MAX)) begin
      asum = asum - (CW+1)'(POP_MAX);
    end
  end

  // Eviction threshold
  always_comb begin
    if (target_size == '0) begin
      tgt = 32'(orig);
    end else if (32'(target_size) > 32'(POP_MAX)) begin
      tgt = 32'(POP_MAX);
    end else begin
      tgt = 32'(target_size);
    end
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    s_next      = s;
    pos_next    = pos;
    orig_next   = orig;
    key_next    = key;
    nid_next    = nid;
    evp_next    = evp;
    status_next = status;
    ev_next     = ev;
    fb_next     = fb;
    ev_id_next  = ev_id;
    ev_fit_next = ev_fit;
    head_next   = head;
    alen_next   = alen;
    t_we        = 1'b0;
    t_waddr     = s;
    t_wdata     = t_rdata;
    t_raddr     = s;
    a_we        = 1'b0;
    a_waddr     = AW'(asum);
    a_wdata     = push.value;
    a_raddr     = head;
    elite_step  = 1'b0;

    unique case (state)
      ept_pkg::S_IDLE: begin
        if (start) begin
          key_next    = item.new_fitness;
          nid_next    = item.new_id;
          orig_next   = cnt;
          evp_next    = 1'b0;
          status_next = 1'b0;
          ev_next     = 1'b0;
          fb_next     = 1'b0;
          ev_id_next  = '0;
          ev_fit_next = '0;
          if (cnt == '0) begin
            pos_next   = '0;
            state_next = ept_pkg::S_INS;
          end else begin
            t_raddr    = '0;
            s_next     = '0;
            state_next = ept_pkg::S_SCAN;
          end
        end
      end

      // Walk the table for the first entry not below the key
      ept_pkg::S_SCAN: begin
        if (less && (s + PW'(1) != cnt)) begin
          t_raddr = s + PW'(1);
          s_next  = s + PW'(1);
        end else if (!evp) begin
          pos_next = pos_sc;
          if (!less && rd_fit == key) begin
            status_next = 1'b1;
            state_next  = ept_pkg::S_DONE;
          end else if (pos_sc == cnt) begin
            state_next = ept_pkg::S_INS;
          end else begin
            t_raddr    = cnt - PW'(1);
            s_next     = cnt - PW'(1);
            state_next = ept_pkg::S_SHUP;
          end
        end else begin
          if (!less && rd_fit == key) begin
            pos_next = pos_sc;
          end else begin
            pos_next = '0;
            fb_next  = 1'b1;
          end
          state_next = ept_pkg::S_EV_RD;
        end
      end

      // Open a slot: move entries up by one
      ept_pkg::S_SHUP: begin
        t_we    = 1'b1;
        t_waddr = s + PW'(1);
        if (s == pos) begin
          state_next = ept_pkg::S_INS;
        end else begin
          t_raddr = s - PW'(1);
          s_next  = s - PW'(1);
        end
      end

      ept_pkg::S_INS: begin
        t_we       = 1'b1;
        t_waddr    = pos;
        t_wdata    = {key, nid};
        cnt_next   = cnt + PW'(1);
        state_next = ept_pkg::S_ELITE;
      end

      // Update the elite set; push any value it hands on to the age queue
      ept_pkg::S_ELITE: begin
        elite_step = 1'b1;
        if (push.valid) begin
          a_we      = 1'b1;
          head_next = h1;
          alen_next = l1 + CW'(1);
        end
        state_next = ept_pkg::S_CHK;
      end

      ept_pkg::S_CHK: begin
        if (32'(cnt) > tgt) begin
          ev_next = 1'b1;
          if (alen != '0) begin
            a_raddr    = head;
            head_next  = (head == AW'(POP_MAX - 1)) ? '0 : head + AW'(1);
            alen_next  = alen - CW'(1);
            state_next = ept_pkg::S_AGE_LAT;
          end else begin
            pos_next   = '0;
            fb_next    = 1'b1;
            state_next = ept_pkg::S_EV_RD;
          end
        end else begin
          state_next = ept_pkg::S_DONE;
        end
      end

      // Search the table for the oldest queued fitness
      ept_pkg::S_AGE_LAT: begin
        key_next   = a_rdata;
        evp_next   = 1'b1;
        t_raddr    = '0;
        s_next     = '0;
        state_next = ept_pkg::S_SCAN;
      end

      ept_pkg::S_EV_RD: begin
        t_raddr    = pos;
        state_next = ept_pkg::S_EV_LAT;
      end

      ept_pkg::S_EV_LAT: begin
        ev_fit_next = rd_fit;
        ev_id_next  = rd_id;
        if (pos + PW'(1) < cnt) begin
          t_raddr    = pos + PW'(1);
          s_next     = pos + PW'(1);
          state_next = ept_pkg::S_SHDN;
        end else begin
          cnt_next   = cnt - PW'(1);
          state_next = ept_pkg::S_DONE;
        end
      end

      // Close the gap: move entries down by one
      ept_pkg::S_SHDN: begin
        t_we    = 1'b1;
        t_waddr = s - PW'(1);
        if (s + PW'(1) == cnt) begin
          cnt_next   = cnt - PW'(1);
          state_next = ept_pkg::S_DONE;
        end else begin
          t_raddr = s + PW'(1);
          s_next  = s + PW'(1);
        end
      end

      ept_pkg::S_DONE: begin
        state_next = ept_pkg::S_IDLE;
      end

      default: begin
        state_next = ept_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ept_pkg::S_IDLE;
      cnt    <= '0;
      head   <= '0;
      alen   <= '0;
      evp    <= 1'b0;
      status <= 1'b0;
      ev     <= 1'b0;
      fb     <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      head   <= head_next;
      alen   <= alen_next;
      evp    <= evp_next;
      status <= status_next;
      ev     <= ev_next;
      fb     <= fb_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s      <= s_next;
    pos    <= pos_next;
    orig   <= orig_next;
    key    <= key_next;
    nid    <= nid_next;
    ev_id  <= ev_id_next;
    ev_fit <= ev_fit_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      elite_count <= '0;
      target_size <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ept_pkg::REG_ELITE_COUNT: elite_count <= cfg_data[3:0];
        ept_pkg::REG_TARGET_SIZE: target_size <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/ept_ram.sv
// Generic simple dual-port RAM with registered read
module ept_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ept_elite.sv
// Elite set: sorted register file of the best fitness values
module ept_elite #(
  parameter int ELITE_MAX = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3:0]              elite_count,
  input  logic                    step,
  input  logic [ept_pkg::FIT_W-1:0] fit,
  output ept_pkg::push_t          push
);

  localparam int EW = $clog2(ELITE_MAX + 1);

  logic [ept_pkg::FIT_W-1:0] elite [ELITE_MAX];
  logic [ept_pkg::FIT_W-1:0] elite_next [ELITE_MAX];
  logic [EW-1:0]             len;
  logic [EW-1:0]             len_next;
  logic [EW-1:0]             p;
  logic                      hit;
  int                        k;

  always_comb begin
    // Clamp the configured size
    k = (int'(elite_count) > ELITE_MAX) ? ELITE_MAX : int'(elite_count);

    // Count members below the candidate and look for an equal one
    p   = '0;
    hit = 1'b0;
    for (int j = 0; j < ELITE_MAX; j++) begin
      if (j < int'(len)) begin
        if (ept_pkg::fit_less(elite[j], fit)) begin
          p = p + EW'(1);
        end
        if (elite[j] == fit) begin
          hit = 1'b1;
        end
      end
    end

    elite_next = elite;
    len_next   = len;
    push.valid = 1'b0;
    push.value = fit;

    priority if (k == 0) begin
      push.valid = 1'b1;
    end else if (int'(len) < k) begin
      // Insert in order
      if (!hit && int'(len) < ELITE_MAX) begin
        for (int j = 0; j < ELITE_MAX; j++) begin
          if (j == int'(p)) begin
            elite_next[j] = fit;
          end else if (j > int'(p)) begin
            elite_next[j] = elite[(j == 0) ? 0 : j - 1];
          end
        end
        len_next = len + EW'(1);
      end
    end else if (len != '0 && ept_pkg::fit_less(elite[0], fit)) begin
      // Drop the weakest to the age queue, then insert the candidate unless it is already a member
      push.valid = 1'b1;
      push.value = elite[0];
      for (int j = 0; j < ELITE_MAX; j++) begin
        if (hit || j < int'(p) - 1) begin
          elite_next[j] = elite[(j == ELITE_MAX - 1) ? j : j + 1];
        end else if (j == int'(p) - 1) begin
          elite_next[j] = fit;
        end
      end
      if (hit) begin
        len_next = len - EW'(1);
      end
    end else begin
      push.valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (step) begin
      len <= len_next;
    end
  end

  // Values need no reset
  always_ff @(posedge clk) begin
    if (step) begin
      elite <= elite_next;
    end
  end

endmodule
